// ----- rtl/sorted_first_last_index_search_macros.svh -----
// Assertion macros shared by the checker of the sorted first/last index search block
`ifndef SORTED_FIRST_LAST_INDEX_SEARCH_MACROS_SVH
`define SORTED_FIRST_LAST_INDEX_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on i_clk and ignored while i_rst_n is low
`define SFLIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and ignored while i_rst_n is low
`define SFLIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sflis_pkg.sv -----
// Types and constants shared by the sorted first/last index search block
package sflis_pkg;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned VAL_W = 32;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] value;
        logic                    start_new;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
    } t_out_item;

endpackage

// ----- rtl/sflis_store.sv -----
// Element memory: one write port, one read port with registered read data
module sflis_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [sflis_pkg::VAL_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [sflis_pkg::VAL_W-1:0] o_rd_data
);
    import sflis_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sflis_search.sv -----
// Search sequencer: two binary searches through one shared compare unit, plus result register
module sflis_search #(
    parameter int unsigned AW = 10,
    parameter int unsigned CW = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [sflis_pkg::VAL_W-1:0] i_key,
    input  logic [CW-1:0]                      i_count,
    output logic                               o_busy,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  logic [sflis_pkg::VAL_W-1:0]        i_rd_data,
    output logic                               o_res_valid,
    input  logic                               i_res_stall,
    output sflis_pkg::t_out_item               o_res
);
    import sflis_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi1, n_hi1;       // exclusive upper bound
    logic [AW-1:0]           r_mid, n_mid;
    logic [AW-1:0]           r_hit, n_hit;
    logic                    r_hit_vld, n_hit_vld;
    logic [AW-1:0]           r_first, n_first;
    logic                    r_phase, n_phase;   // 0: lowest index, 1: highest index
    t_out_item               r_res, n_res;
    t_out_item               r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic                    range_open;
    logic signed [VAL_W-1:0] probe_val;

    always_comb begin
        mid_sum    = {1'b0, r_lo} + {1'b0, r_hi1} - (CW+1)'(1);
        mid        = mid_sum[CW:1];
        range_open = (r_lo < r_hi1);
        probe_val  = $signed(i_rd_data);

        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi1       = r_hi1;
        n_mid       = r_mid;
        n_hit       = r_hit;
        n_hit_vld   = r_hit_vld;
        n_first     = r_first;
        n_phase     = r_phase;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once the transfer completes
        if (r_out_valid && !i_res_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key     = i_key;
                    n_lo      = '0;
                    n_hi1     = i_count;
                    n_phase   = 1'b0;
                    n_hit_vld = 1'b0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                if (range_open) begin
                    n_mid   = mid[AW-1:0];
                    n_state = S_CMP;
                end else if (!r_phase) begin
                    if (!r_hit_vld) begin
                        n_res   = '{found: 1'b0, first_index: '0, last_index: '0};
                        n_state = S_DONE;
                    end else begin
                        // second search starts at the first hit
                        n_first   = r_hit;
                        n_lo      = CW'(r_hit);
                        n_hi1     = i_count;
                        n_phase   = 1'b1;
                        n_hit_vld = 1'b0;
                    end
                end else begin
                    n_res = '{found:       1'b1,
                              first_index: IDX_W'(r_first),
                              last_index:  r_hit_vld ? IDX_W'(r_hit) : IDX_W'(r_first)};
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (probe_val > r_key) begin
                    n_hi1 = CW'(r_mid);
                end else if (probe_val < r_key) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hit     = r_mid;
                    n_hit_vld = 1'b1;
                    if (!r_phase) begin
                        n_hi1 = CW'(r_mid);
                    end else begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end
                end
                n_state = S_PROBE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (!n_out_valid) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_hit_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_hit_vld   <= n_hit_vld;
        end
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi1   <= n_hi1;
        r_mid   <= n_mid;
        r_hit   <= n_hit;
        r_first <= n_first;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rd_en     = (r_state == S_PROBE) && range_open;
    assign o_rd_addr   = mid[AW-1:0];
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ----- rtl/sorted_first_last_index_search.sv -----
// Append: the next item is taken in the following cycle.
// Query: two binary searches; each memory probe issues the address in S_PROBE, then
// compares the registered read data in S_CMP. The block takes no item until the result
// register loads. The memory read port sets the pace.
// A finished result waits in its own register, so new items are taken while it is stalled.
// Reset (synchronous, active low) empties the array and clears the sequencer and result valid.
module sorted_first_last_index_search #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sflis_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sflis_pkg::t_out_item o_out_item
);
    import sflis_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    base;
    logic             in_xfer;
    logic             append;
    logic             wr_en;
    logic             busy;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign append  = in_xfer && (i_in_item.cmd == CMD_APPEND);
    assign base    = i_in_item.start_new ? '0 : r_count;
    assign wr_en   = append && (base < CW'(MAX_ELEMENTS));

    always_comb begin
        n_count = r_count;
        if (append) begin
            n_count = wr_en ? base + CW'(1) : base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    sflis_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (base[AW-1:0]),
        .i_wr_data (i_in_item.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sflis_search #(
        .AW (AW),
        .CW (CW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer && (i_in_item.cmd == CMD_QUERY)),
        .i_key       (i_in_item.value),
        .i_count     (r_count),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (o_out_valid),
        .i_res_stall (i_out_stall),
        .o_res       (o_out_item)
    );

    assign o_in_stall = busy;

endmodule

// ----- rtl/sflis_checker.sv -----
// Port-level checks of the sorted first/last index search block and their bind
`include "sorted_first_last_index_search_macros.svh"

module sflis_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input sflis_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sflis_pkg::t_out_item o_out_item
);
    import sflis_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    `SFLIS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "result changed while stalled")
    `SFLIS_ASSERT_NEXT(a_query_busy, in_xfer && (i_in_item.cmd == CMD_QUERY), o_in_stall, "query transfer did not start a search")
    `SFLIS_ASSERT_NEXT(a_append_free, in_xfer && (i_in_item.cmd == CMD_APPEND), !o_in_stall, "append transfer left the input stalled")
    `SFLIS_ASSERT_NOW(a_absent_zero, o_out_valid && !o_out_item.found, (o_out_item.first_index == '0) && (o_out_item.last_index == '0), "absent key with non-zero index")

endmodule

bind sorted_first_last_index_search sflis_checker u_sflis_checker (.*);
